/* hw/rtl/ipv4rt_pkg.sv */
`default_nettype none

package ipv4rt_pkg;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_PREFIX = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;

  localparam logic [1:0] KIND_TUNNEL = 2'd0;
  localparam logic [1:0] KIND_BYPASS = 2'd1;
  localparam logic [1:0] KIND_BLOCK  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [5:0] PREFIX_MAX = 6'd32;

  typedef struct packed {
    logic        func;
    logic [31:0] route_network;
    logic [5:0]  route_prefix;
    logic [1:0]  route_kind;
    logic [15:0] route_metric;
    logic [31:0] dest_addr;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] result_kind;
    logic       matched;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CHECK,
    S_INS_CMP,
    S_INS_PUT,
    S_LK_READ,
    S_LK_CMP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       rd_en;
    logic       rd_prev;
    logic       rd_next;
    logic       ptr_dec;
    logic       ptr_inc;
    logic       wr_shift;
    logic       wr_new_up;
    logic       wr_new_here;
    logic       cnt_inc;
    logic       done;
    logic       hit;
    logic [1:0] status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic prefix_bad;
    logic full;
    logic empty;
    logic goes_before;
    logic hit;
    logic ptr_first;
    logic ptr_last;
  } sts_t;

  function automatic logic [31:0] prefix_to_mask(input logic [5:0] plen);
    logic [31:0] m;
    if (plen == 6'd0) begin
      m = 32'd0;
    end else begin
      m = 32'hFFFF_FFFF << (PREFIX_MAX - plen);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ipv4rt_ctrl.sv */
`default_nettype none

module ipv4rt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          start_func,
  output logic               busy,
  input  wire ipv4rt_pkg::sts_t sts,
  output ipv4rt_pkg::cmd_t   cmd
);
  import ipv4rt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = (start_func == FUNC_LOOKUP) ? S_LK_READ : S_INS_CHECK;
        end
      end
      S_INS_CHECK: begin
        if (sts.prefix_bad) begin
          cmd.done   = 1'b1;
          cmd.status = ST_BAD_PREFIX;
          state_nxt  = S_IDLE;
        end else if (sts.full) begin
          cmd.done   = 1'b1;
          cmd.status = ST_FULL;
          state_nxt  = S_IDLE;
        end else if (sts.empty) begin
          cmd.wr_new_here = 1'b1;
          cmd.cnt_inc     = 1'b1;
          cmd.done        = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        // The table is scanned from its tail; every entry the new route
        // goes ahead of moves up one place.
        if (sts.goes_before) begin
          cmd.wr_shift = 1'b1;
          if (sts.ptr_first) begin
            state_nxt = S_INS_PUT;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_prev = 1'b1;
            cmd.ptr_dec = 1'b1;
          end
        end else begin
          cmd.wr_new_up = 1'b1;
          cmd.cnt_inc   = 1'b1;
          cmd.done      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_INS_PUT: begin
        cmd.wr_new_here = 1'b1;
        cmd.cnt_inc     = 1'b1;
        cmd.done        = 1'b1;
        state_nxt       = S_IDLE;
      end
      S_LK_READ: begin
        if (sts.empty) begin
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_LK_CMP;
        end
      end
      S_LK_CMP: begin
        if (sts.hit) begin
          cmd.done  = 1'b1;
          cmd.hit   = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.ptr_last) begin
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          cmd.ptr_inc = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/ipv4rt_dpath.sv */
`default_nettype none

module ipv4rt_dpath #(
  parameter int ROUTE_DEPTH = 16,
  parameter int METRIC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ipv4rt_pkg::in_item_t in_item,
  input  wire ipv4rt_pkg::cmd_t     cmd,
  output ipv4rt_pkg::sts_t          sts,
  output logic                      out_valid,
  output ipv4rt_pkg::out_item_t     out_item
);
  import ipv4rt_pkg::*;

  localparam int IDX_W = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
  localparam int CNT_W = $clog2(ROUTE_DEPTH + 1);

  logic [31:0]            net_mem  [ROUTE_DEPTH];
  logic [31:0]            mask_mem [ROUTE_DEPTH];
  logic [5:0]             pfx_mem  [ROUTE_DEPTH];
  logic [1:0]             kind_mem [ROUTE_DEPTH];
  logic [METRIC_BITS-1:0] met_mem  [ROUTE_DEPTH];

  in_item_t               item_r;
  logic [IDX_W-1:0]       ptr_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [31:0]            rd_net_r;
  logic [31:0]            rd_mask_r;
  logic [5:0]             rd_pfx_r;
  logic [1:0]             rd_kind_r;
  logic [METRIC_BITS-1:0] rd_met_r;
  out_item_t              out_r;
  logic                   out_valid_r;

  logic [METRIC_BITS-1:0] new_met;
  logic [1:0]             new_kind;
  logic [31:0]            new_mask;
  logic [IDX_W-1:0]       ptr_init;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       wr_addr;
  logic                   wr_en;
  logic [31:0]            wr_net;
  logic [31:0]            wr_mask;
  logic [5:0]             wr_pfx;
  logic [1:0]             wr_kind;
  logic [METRIC_BITS-1:0] wr_met;

  assign new_met  = METRIC_BITS'(item_r.route_metric);
  assign new_kind = (item_r.route_kind == KIND_UNUSED) ? KIND_BLOCK : item_r.route_kind;
  assign new_mask = prefix_to_mask(item_r.route_prefix);

  // Inserts scan from the last stored entry down, lookups from the first up.
  assign ptr_init = ((in_item.func == FUNC_LOOKUP) || (cnt_r == '0)) ? '0
                  : IDX_W'(cnt_r - CNT_W'(1));

  always_comb begin
    if (cmd.rd_prev) begin
      rd_addr = ptr_r - IDX_W'(1);
    end else if (cmd.rd_next) begin
      rd_addr = ptr_r + IDX_W'(1);
    end else begin
      rd_addr = ptr_r;
    end
  end

  assign wr_en   = cmd.wr_shift | cmd.wr_new_up | cmd.wr_new_here;
  assign wr_addr = cmd.wr_new_here ? ptr_r : ptr_r + IDX_W'(1);
  assign wr_net  = cmd.wr_shift ? rd_net_r  : item_r.route_network;
  assign wr_mask = cmd.wr_shift ? rd_mask_r : new_mask;
  assign wr_pfx  = cmd.wr_shift ? rd_pfx_r  : item_r.route_prefix;
  assign wr_kind = cmd.wr_shift ? rd_kind_r : new_kind;
  assign wr_met  = cmd.wr_shift ? rd_met_r  : new_met;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      net_mem[wr_addr]  <= wr_net;
      mask_mem[wr_addr] <= wr_mask;
      pfx_mem[wr_addr]  <= wr_pfx;
      kind_mem[wr_addr] <= wr_kind;
      met_mem[wr_addr]  <= wr_met;
    end
    if (cmd.rd_en) begin
      rd_net_r  <= net_mem[rd_addr];
      rd_mask_r <= mask_mem[rd_addr];
      rd_pfx_r  <= pfx_mem[rd_addr];
      rd_kind_r <= kind_mem[rd_addr];
      rd_met_r  <= met_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.capture) begin
      ptr_r <= ptr_init;
    end else if (cmd.ptr_dec) begin
      ptr_r <= ptr_r - IDX_W'(1);
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      out_valid_r <= cmd.done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      out_r.status  <= cmd.status;
      out_r.matched <= cmd.hit;
      if (cmd.hit) begin
        out_r.result_kind <= rd_kind_r;
      end else if (item_r.func == FUNC_LOOKUP) begin
        out_r.result_kind <= KIND_BYPASS;
      end else begin
        out_r.result_kind <= KIND_TUNNEL;
      end
    end
  end

  always_comb begin
    sts.prefix_bad = (item_r.route_prefix > PREFIX_MAX);
    sts.full       = (cnt_r == CNT_W'(ROUTE_DEPTH));
    sts.empty      = (cnt_r == '0);
    // Ties on both keys keep the stored entry ahead of the new one.
    if (new_met != rd_met_r) begin
      sts.goes_before = (new_met < rd_met_r);
    end else begin
      sts.goes_before = (item_r.route_prefix > rd_pfx_r);
    end
    sts.hit       = ((item_r.dest_addr & rd_mask_r) == rd_net_r);
    sts.ptr_first = (ptr_r == '0);
    sts.ptr_last  = ((CNT_W'(ptr_r) + CNT_W'(1)) == cnt_r);
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

/* hw/rtl/ipv4_route_table_top.sv */
`default_nettype none

// A lookup reads the stored entries from the first up and stops at the first hit
// or at the last entry; a lookup into an empty table answers with no match unread.
// An insert reads from the last entry down and moves up each entry the new route goes
// ahead of; an insert into an empty table, or one rejected, reads nothing. busy is high
// whenever the controller is not idle. Reset clears the entry count, the controller and the strobe.
// The receiver cannot stall: each result is strobed by out_valid for exactly one cycle.
module ipv4_route_table_top #(
  parameter int ROUTE_DEPTH = 16,
  parameter int METRIC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire ipv4rt_pkg::in_item_t in_item,
  output logic                      out_valid,
  output ipv4rt_pkg::out_item_t     out_item
);
  import ipv4rt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ipv4rt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .start_func (in_item.func),
    .busy       (busy),
    .sts        (sts),
    .cmd        (cmd)
  );

  ipv4rt_dpath #(
    .ROUTE_DEPTH (ROUTE_DEPTH),
    .METRIC_BITS (METRIC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

/* tb/sv/ipv4_route_table_top_tb.sv */
`default_nettype none

module ipv4_route_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipv4rt_pkg::*;

  localparam int ROUTE_DEPTH = 16;
  localparam int METRIC_BITS = 16;

  typedef struct packed {
    logic [31:0] network;
    logic [31:0] mask;
    logic [5:0]  prefix;
    logic [1:0]  kind;
    logic [15:0] metric;
  } route_entry_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  // Our own copy of the table, kept in the order the block must hold it.
  route_entry_t routes[ROUTE_DEPTH];
  int           route_count = 0;

  out_item_t pending_answers[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        burst_left = 0;
  bit        pace_quiet = 1'b0;

  ipv4_route_table_top #(
    .ROUTE_DEPTH(ROUTE_DEPTH),
    .METRIC_BITS(METRIC_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] mask_of(input logic [5:0] plen);
    logic [31:0] m;
    if (plen == 6'd0) begin
      m = 32'd0;
    end else begin
      m = 32'hFFFF_FFFF << (32 - plen);
    end
    return m;
  endfunction

  // Updates the table copy for an insert and returns the answer the block owes.
  function automatic out_item_t route_answer(input in_item_t it);
    out_item_t    r;
    route_entry_t e;
    int           pos;
    bit           found;
    r = '0;
    found = 1'b0;
    if (it.func == FUNC_INSERT) begin
      if (it.route_prefix > PREFIX_MAX) begin
        r.status = ST_BAD_PREFIX;
      end else if (route_count >= ROUTE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        e.network = it.route_network;
        e.mask    = mask_of(it.route_prefix);
        e.prefix  = it.route_prefix;
        e.kind    = (it.route_kind == KIND_UNUSED) ? KIND_BLOCK : it.route_kind;
        e.metric  = it.route_metric;
        pos = route_count;
        // A new route lands after every entry that ties with it on both keys.
        for (int j = 0; j < route_count && !found; j++) begin
          if (e.metric < routes[j].metric ||
              (e.metric == routes[j].metric && e.prefix > routes[j].prefix)) begin
            pos = j;
            found = 1'b1;
          end
        end
        for (int j = route_count; j > pos; j--) begin
          routes[j] = routes[j - 1];
        end
        routes[pos] = e;
        route_count++;
        r.status = ST_OK;
      end
    end else begin
      r.result_kind = KIND_BYPASS;
      for (int i = 0; i < route_count && !found; i++) begin
        if ((it.dest_addr & routes[i].mask) == routes[i].network) begin
          r.result_kind = routes[i].kind;
          r.matched = 1'b1;
          found = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic in_item_t make_insert(input logic [31:0] net, input logic [5:0] plen,
                                           input logic [1:0] kind, input logic [15:0] metric);
    in_item_t it;
    it.func          = FUNC_INSERT;
    it.route_network = net;
    it.route_prefix  = plen;
    it.route_kind    = kind;
    it.route_metric  = metric;
    it.dest_addr     = $urandom;
    return it;
  endfunction

  function automatic in_item_t make_lookup(input logic [31:0] dest);
    in_item_t it;
    it.func          = FUNC_LOOKUP;
    it.route_network = $urandom;
    it.route_prefix  = 6'($urandom_range(0, 63));
    it.route_kind    = 2'($urandom_range(0, 3));
    it.route_metric  = 16'($urandom);
    it.dest_addr     = dest;
    return it;
  endfunction

  // Mostly well-formed routes: host bits cleared and metrics drawn from a
  // narrow range now and then so that ties happen.
  function automatic in_item_t random_route();
    logic [5:0]  plen;
    logic [31:0] net;
    logic [15:0] metric;
    plen = 6'($urandom_range(1, 32));
    net = $urandom;
    if ($urandom_range(0, 9) != 0) begin
      net = net & mask_of(plen);
    end
    metric = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    return make_insert(net, plen, 2'($urandom_range(0, 3)), metric);
  endfunction

  // Destination inside a stored route about half of the time.
  function automatic logic [31:0] pick_dest();
    int          i;
    logic [31:0] dest;
    dest = $urandom;
    if (route_count > 0 && $urandom_range(0, 1) == 0) begin
      i = $urandom_range(0, route_count - 1);
      dest = (routes[i].network & routes[i].mask) | (dest & ~routes[i].mask);
    end
    return dest;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  // Sends one item; the sender runs in bursts with random gaps between them.
  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (pace_quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_item <= it;
    // busy is settled at the falling edge; once it is low the next rising edge takes the item.
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_answers = {pending_answers, route_answer(it)};
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    burst_left = 0;
    while (pending_answers.size() > 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_answers.size() == 0) begin
        report_mismatch("result with no item waiting, status", int'(out_item.status), -1);
      end else begin
        want = pending_answers.pop_front();
        if (out_item.status !== want.status)
          report_mismatch("status", int'(out_item.status), int'(want.status));
        if (out_item.result_kind !== want.result_kind)
          report_mismatch("result_kind", int'(out_item.result_kind), int'(want.result_kind));
        if (out_item.matched !== want.matched)
          report_mismatch("matched", int'(out_item.matched), int'(want.matched));
      end
    end
  end

  task automatic test_empty_table();
    send_item(make_lookup(32'h0000_0000));
    send_item(make_lookup(32'hFFFF_FFFF));
    send_item(make_insert(32'h0A00_0000, 6'd33, KIND_TUNNEL, 16'd5));
    send_item(make_insert(32'hFFFF_FFFF, 6'd63, KIND_BLOCK, 16'hFFFF));
  endtask

  task automatic test_insert_order();
    send_item(make_insert(32'h0A00_0000, 6'd8, KIND_TUNNEL, 16'd100));
    send_item(make_insert(32'hC0A8_0100, 6'd24, KIND_BLOCK, 16'd100));
    send_item(make_insert(32'hC0A8_0101, 6'd32, KIND_UNUSED, 16'd0));
    send_item(make_insert(32'hFFFF_FFFF, 6'd32, KIND_BYPASS, 16'hFFFF));
    // Same keys as the first route, so it must stay behind it.
    send_item(make_insert(32'h0A00_0000, 6'd8, KIND_BLOCK, 16'd100));
    // Host bits set, so this route can never match.
    send_item(make_insert(32'h0A00_0001, 6'd8, KIND_BLOCK, 16'd0));
    send_item(make_insert(32'h1234_5678, 6'd0, KIND_TUNNEL, 16'd0));
  endtask

  task automatic test_lookup_order();
    send_item(make_lookup(32'h0A12_3456));
    send_item(make_lookup(32'hC0A8_0105));
    send_item(make_lookup(32'hC0A8_0101));
    send_item(make_lookup(32'hFFFF_FFFF));
    send_item(make_lookup(32'h0A00_0001));
    send_item(make_lookup(32'h0B00_0000));
    send_item(make_lookup(32'h0000_0000));
    send_item(make_lookup(32'h7FFF_FFFF));
  endtask

  // Fills the table up to one free slot, leaving room for the default route.
  task automatic test_random_fill();
    int       roll;
    in_item_t it;
    for (int n = 0; n < 950; n++) begin
      pace_quiet = (n >= 400 && n < 520);
      roll = $urandom_range(0, 99);
      if (roll < 30 && route_count < ROUTE_DEPTH - 1) begin
        send_item(random_route());
      end else if (roll < 38) begin
        it = random_route();
        it.route_prefix = 6'($urandom_range(33, 63));
        send_item(it);
      end else begin
        send_item(make_lookup(pick_dest()));
      end
    end
    pace_quiet = 1'b0;
  endtask

  task automatic test_default_route();
    wait_drain();
    send_item(make_insert(32'h0000_0000, 6'd0, KIND_TUNNEL, 16'hFFFF));
    for (int n = 0; n < 30; n++) begin
      send_item(make_lookup($urandom));
    end
  endtask

  task automatic test_full_table();
    in_item_t it;
    for (int n = 0; n < 950; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        it = make_insert($urandom, 6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)),
                         16'($urandom));
        send_item(it);
      end else begin
        send_item(make_lookup(pick_dest()));
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_insert_order();
    test_lookup_order();
    test_random_fill();
    test_default_route();
    test_full_table();
    wait_drain();
    // Room for a stray result from the longest scan.
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
